// ----- sv/bounded_integer_stack_ops_unit_defines.svh -----
// Assertion macros shared by the bounded integer stack RTL.
// Stands alone: no package or module needed.
`ifndef BOUNDED_INTEGER_STACK_OPS_UNIT_DEFINES_SVH
`define BOUNDED_INTEGER_STACK_OPS_UNIT_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define BIS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define BIS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bisops_pkg.sv -----
// Package for the bounded integer stack: sizes, codes, beat and state types.
// No dependencies.
package bisops_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    // operation codes
    localparam logic [2:0] ACT_PUSH = 3'd0;
    localparam logic [2:0] ACT_POP  = 3'd1;
    localparam logic [2:0] ACT_PALL = 3'd2;
    localparam logic [2:0] ACT_PINT = 3'd3;
    localparam logic [2:0] ACT_SWAP = 3'd4;

    // result status codes
    localparam logic [2:0] STS_DONE       = 3'd0;
    localparam logic [2:0] STS_VALUE      = 3'd1;
    localparam logic [2:0] STS_POP_EMPTY  = 3'd2;
    localparam logic [2:0] STS_TOP_EMPTY  = 3'd3;
    localparam logic [2:0] STS_SWAP_SHORT = 3'd4;
    localparam logic [2:0] STS_FULL       = 3'd5;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic [2:0]               status;
        logic                     last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWAP_RD,
        ST_SWAP_WR
    } t_state;

endpackage

// ----- sv/bisops_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bisops_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/bounded_integer_stack_ops_unit.sv -----
// Top level of the bounded integer stack: control FSM, entry count, output register.
// Depends on bisops_pkg, bisops_ram and bounded_integer_stack_ops_unit_defines.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per
//   operation: push, pop, print all, print top or swap. Output channel
//   (o_out_valid / i_out_ready / o_out_data) carries result beats; the final
//   beat caused by an operation has last set.
//   Entries live in a 64 x 32 RAM with a registered read port.
//   An operation is taken in the idle cycle, which also issues the read of the
//   top entry; the result is loaded into the output register once that is free.
//   Swap reads top, reads second, writes top, writes second through the
//   single RAM read and write ports; print all does one RAM read per
//   reported entry.
//   Only one operation is in flight; a new one is taken only after all result
//   beats of the previous one are loaded, so no read overlaps a pending write.
//   Reset clears the entry count, FSM and output valid; the RAM is not
//   cleared and needs no clearing pass. When the receiver stalls, the output
//   register holds its beat and the FSM waits (a swap still writes the top slot).
module bounded_integer_stack_ops_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bisops_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bisops_pkg::t_out_item o_out_data
);
    import bisops_pkg::*;

`include "bounded_integer_stack_ops_unit_defines.svh"

    // state registers
    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [ADDR_W-1:0]        r_idx;
    logic [ADDR_W-1:0]        n_idx;
    logic [2:0]               r_act;
    logic [DATA_W-1:0]        r_val;
    logic [DATA_W-1:0]        r_tmp;
    logic                     r_out_valid;
    t_out_item                r_out;

    // RAM port controls
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [DATA_W-1:0]        rd_data;

    // result and control strobes
    logic                     emit;
    t_out_item                emit_item;
    logic                     tmp_load;
    logic                     accept;
    logic                     out_free;

    logic                     is_empty;
    logic                     is_full;
    logic                     is_short;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CNT_W-1:0]         cnt_m2;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= CNT_W'(STACK_DEPTH));
    assign is_short = (r_count < CNT_W'(2));
    assign cnt_m1   = r_count - CNT_W'(1);
    assign cnt_m2   = r_count - CNT_W'(2);

    bisops_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_act)
                    ACT_SWAP: begin
                        if (!is_short) begin
                            n_state = ST_SWAP_RD;
                        end else if (out_free) begin
                            n_state = ST_IDLE;
                        end
                    end
                    ACT_PALL: begin
                        if (out_free && (is_empty || r_idx == '0)) begin
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            n_state = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_SWAP_RD: begin
                n_state = ST_SWAP_WR;
            end
            ST_SWAP_WR: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        o_in_ready = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_count[ADDR_W-1:0];
        wr_data    = r_val;
        rd_en      = 1'b0;
        rd_addr    = cnt_m1[ADDR_W-1:0];
        emit       = 1'b0;
        emit_item  = '{out_value: '0, status: STS_DONE, last: 1'b1};
        tmp_load   = 1'b0;
        n_count    = r_count;
        n_idx      = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                rd_en      = i_in_valid;
                n_idx      = cnt_m1[ADDR_W-1:0];
            end
            ST_EXEC: begin
                unique case (r_act)
                    ACT_PUSH: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (is_full) begin
                                emit_item.status = STS_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                    end
                    ACT_POP: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (is_empty) begin
                                emit_item.status = STS_POP_EMPTY;
                            end else begin
                                n_count = cnt_m1;
                            end
                        end
                    end
                    ACT_PALL: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (!is_empty) begin
                                emit_item.out_value = rd_data;
                                emit_item.status    = STS_VALUE;
                                emit_item.last      = (r_idx == '0);
                                // fetch the next entry down
                                if (r_idx != '0) begin
                                    rd_en   = 1'b1;
                                    rd_addr = r_idx - ADDR_W'(1);
                                    n_idx   = r_idx - ADDR_W'(1);
                                end
                            end
                        end
                    end
                    ACT_PINT: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (is_empty) begin
                                emit_item.status = STS_TOP_EMPTY;
                            end else begin
                                emit_item.out_value = rd_data;
                                emit_item.status    = STS_VALUE;
                            end
                        end
                    end
                    ACT_SWAP: begin
                        if (is_short) begin
                            if (out_free) begin
                                emit             = 1'b1;
                                emit_item.status = STS_SWAP_SHORT;
                            end
                        end else begin
                            // latch top, fetch second
                            tmp_load = 1'b1;
                            rd_en    = 1'b1;
                            rd_addr  = cnt_m2[ADDR_W-1:0];
                        end
                    end
                    default: begin
                        emit = out_free;
                    end
                endcase
            end
            ST_SWAP_RD: begin
                wr_en   = 1'b1;
                wr_addr = cnt_m1[ADDR_W-1:0];
                wr_data = rd_data;
            end
            ST_SWAP_WR: begin
                if (out_free) begin
                    wr_en   = 1'b1;
                    wr_addr = cnt_m2[ADDR_W-1:0];
                    wr_data = r_tmp;
                    emit    = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (accept) begin
            r_act <= i_in_data.action;
            r_val <= i_in_data.push_value;
        end
        if (tmp_load) begin
            r_tmp <= rd_data;
        end
        if (emit) begin
            r_out <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BIS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(STACK_DEPTH), "entry count above depth")
    `BIS_ASSERT_IMP(a_emit_room, i_clk, i_rst_n, emit, out_free, "result loaded over a held beat")
    `BIS_ASSERT_IMP(a_no_idle_write, i_clk, i_rst_n, wr_en, r_state != ST_IDLE, "RAM write while idle")
    `BIS_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, accept, r_state == ST_EXEC, "accepted beat not executed")

endmodule
